/* rtl/core/emc_pkg.sv */
// emc_pkg: shared types and constants for the midi channel message encoder
// used by emc_front, emc_fifo, emc_back and the top level; no dependencies

package emc_pkg;

    // function codes of an incoming event
    localparam logic [2:0] FUNC_NOTE_ON  = 3'd0;
    localparam logic [2:0] FUNC_NOTE_OFF = 3'd1;
    localparam logic [2:0] FUNC_PROGRAM  = 3'd2;
    localparam logic [2:0] FUNC_PRESSURE = 3'd3;
    localparam logic [2:0] FUNC_CONTROL  = 3'd4;
    localparam logic [2:0] FUNC_BEND     = 3'd5;

    // upper nibble of the status byte
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CONTROL  = 4'hB;
    localparam logic [3:0] MSG_PROGRAM  = 4'hC;
    localparam logic [3:0] MSG_PRESSURE = 4'hD;
    localparam logic [3:0] MSG_BEND     = 4'hE;

    localparam logic [6:0] DATA_MAX         = 7'h7F;
    localparam logic [6:0] RELEASE_VELOCITY = 7'd64;

    localparam int DEFAULT_FIFO_DEPTH = 2;

    // one encoded message waiting to be sent
    typedef struct packed {
        logic       has_status;
        logic [7:0] status;
        logic [6:0] data0;
        logic [6:0] data1;
        logic       two_data;
    } msg_desc_t;

    // byte position inside a message
    typedef enum logic [1:0] {
        PH_STATUS,
        PH_DATA0,
        PH_DATA1
    } phase_t;

endpackage

/* rtl/core/midi_channel_message_encoder.sv */
// midi_channel_message_encoder: top level, front classifier, descriptor queue
// and byte sender; depends on emc_pkg, emc_front, emc_fifo, emc_back
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | func, channel, key_or_number, amount
//  out     | out_valid / out_ready| out_byte, last_byte
//
// an event gives one to three midi bytes on the output; the byte sender is
// the limit, while the front keeps accepting events until the queue is full
// dropped events are accepted and leave no output and no state change
// reset clears running status, the queue and the output valid flag
// output stalls back up through the queue to in_ready without losing bytes

module midi_channel_message_encoder
#(
    parameter int FIFO_DEPTH = emc_pkg::DEFAULT_FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [4:0]  channel,
    input  logic [7:0]  key_or_number,
    input  logic [15:0] amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);
    import emc_pkg::*;

    logic      push;
    msg_desc_t push_desc;
    logic      queue_full;
    logic      pop;
    logic      head_valid;
    msg_desc_t head_desc;

    emc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .channel       (channel),
        .key_or_number (key_or_number),
        .amount        (amount),
        .queue_full    (queue_full),
        .push          (push),
        .push_desc     (push_desc)
    );

    emc_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    emc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

endmodule

/* rtl/core/emc_front.sv */
// emc_front: accepts channel events, checks ranges, applies running status
// and builds a message descriptor; depends on emc_pkg

module emc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic [4:0]         channel,
    input  logic [7:0]         key_or_number,
    input  logic [15:0]        amount,
    input  logic               queue_full,
    output logic               push,
    output emc_pkg::msg_desc_t push_desc
);
    import emc_pkg::*;

    logic [7:0] running_status_reg;
    logic [7:0] running_status_next;
    logic       accept;
    logic       keep;
    logic [3:0] chan;
    logic [3:0] rs_msg;
    logic       same_chan;
    logic [6:0] vel;
    logic [6:0] key;
    msg_desc_t  desc;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign chan      = channel[3:0];
    assign key       = key_or_number[6:0];
    assign rs_msg    = running_status_reg[7:4];
    assign same_chan = running_status_reg[3:0] == chan;
    assign vel       = (|amount[15:7]) ? DATA_MAX : amount[6:0];

    always_comb
    begin
        keep            = !channel[4];
        desc.has_status = 1'b1;
        desc.status     = {MSG_NOTE_ON, chan};
        desc.data0      = key;
        desc.data1      = vel;
        desc.two_data   = 1'b1;
        case (func)
            FUNC_NOTE_ON:
            begin
                if (key_or_number[7])
                    keep = 1'b0;
                desc.has_status = !(same_chan && rs_msg == MSG_NOTE_ON);
            end
            FUNC_NOTE_OFF:
            begin
                if (key_or_number[7])
                    keep = 1'b0;
                if (same_chan && ((rs_msg == MSG_NOTE_ON && vel == RELEASE_VELOCITY) ||
                                  rs_msg == MSG_NOTE_OFF))
                begin
                    desc.has_status = 1'b0;
                    desc.data1      = (rs_msg == MSG_NOTE_ON) ? 7'd0 : vel;
                end
                else if (vel == RELEASE_VELOCITY)
                begin
                    // release velocity goes out as note on with zero velocity
                    desc.data1 = 7'd0;
                end
                else
                begin
                    desc.status = {MSG_NOTE_OFF, chan};
                end
            end
            FUNC_PROGRAM:
            begin
                if (key_or_number[7])
                    keep = 1'b0;
                desc.status   = {MSG_PROGRAM, chan};
                desc.two_data = 1'b0;
            end
            FUNC_PRESSURE:
            begin
                if (key_or_number[7])
                    keep = 1'b0;
                desc.status     = {MSG_PRESSURE, chan};
                desc.has_status = !(same_chan && rs_msg == MSG_PRESSURE);
                desc.two_data   = 1'b0;
            end
            FUNC_CONTROL:
            begin
                if (key_or_number[7] || key_or_number == 8'd0)
                    keep = 1'b0;
                desc.status     = {MSG_CONTROL, chan};
                desc.has_status = !(same_chan && rs_msg == MSG_CONTROL);
                desc.data1      = amount[6:0];
            end
            FUNC_BEND:
            begin
                if (|amount[15:14])
                    keep = 1'b0;
                desc.status     = {MSG_BEND, chan};
                desc.has_status = !(same_chan && rs_msg == MSG_BEND);
                desc.data0      = amount[6:0];
                desc.data1      = amount[13:7];
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push      = accept && keep;
    assign push_desc = desc;

    always_comb
    begin
        running_status_next = running_status_reg;
        if (push && desc.has_status)
            running_status_next = desc.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            running_status_reg <= 8'd0;
        else
            running_status_reg <= running_status_next;
    end

endmodule

/* rtl/core/emc_fifo.sv */
// emc_fifo: short descriptor queue between front and back
// depends on emc_pkg for the descriptor type

module emc_fifo
#(
    parameter int DEPTH = emc_pkg::DEFAULT_FIFO_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  emc_pkg::msg_desc_t push_desc,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output emc_pkg::msg_desc_t head_desc
);
    import emc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    msg_desc_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

/* rtl/core/emc_back.sv */
// emc_back: takes descriptors from the queue and sends their bytes one per
// cycle, unless out_ready stalls it, through an output register; depends on emc_pkg

module emc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  emc_pkg::msg_desc_t head_desc,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               last_byte
);
    import emc_pkg::*;

    msg_desc_t  cur_reg;
    msg_desc_t  cur_next;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       last_reg;
    logic       last_next;
    logic       emit;
    logic       done;
    logic [7:0] sel_byte;
    logic       sel_last;

    assign emit = cur_valid_reg && (!out_valid_reg || out_ready);
    assign done = emit && sel_last;
    assign pop  = head_valid && (!cur_valid_reg || done);

    // byte picked for the current phase
    always_comb
    begin
        case (phase_reg)
            PH_STATUS:
            begin
                sel_byte = cur_reg.status;
                sel_last = 1'b0;
            end
            PH_DATA0:
            begin
                sel_byte = {1'b0, cur_reg.data0};
                sel_last = !cur_reg.two_data;
            end
            PH_DATA1:
            begin
                sel_byte = {1'b0, cur_reg.data1};
                sel_last = 1'b1;
            end
            default:
            begin
                sel_byte = {1'b0, cur_reg.data1};
                sel_last = 1'b1;
            end
        endcase
    end

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
            phase_next = head_desc.has_status ? PH_STATUS : PH_DATA0;
        else if (emit)
        begin
            case (phase_reg)
                PH_STATUS: phase_next = PH_DATA0;
                PH_DATA0:  phase_next = PH_DATA1;
                default:   phase_next = phase_reg;
            endcase
        end
    end

    always_comb
    begin
        cur_next       = pop ? head_desc : cur_reg;
        cur_valid_next = pop ? 1'b1 : (done ? 1'b0 : cur_valid_reg);
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_byte_next  = emit ? sel_byte : out_byte_reg;
        last_next      = emit ? sel_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_STATUS;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

endmodule
